FILE: design/cdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chamfer distance transform package
// Shared types, field widths, codes and reset values of the distance engine.
// ----------------------------------------------------------------------------
package cdt_pkg;

    localparam int DIST_W     = 24;
    localparam int COST_W     = 16;
    localparam int GRID_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIST_W-1:0] DIST_INF = '1;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_COST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIAGONAL_COST = 2'd2;

    localparam int                RESET_GRID_SIDE     = 256;
    localparam logic [COST_W-1:0] RESET_STRAIGHT_COST = 16'd256;
    localparam logic [COST_W-1:0] RESET_DIAGONAL_COST = 16'd362;

    typedef struct packed {
        logic [1:0]         mode;
        logic [15:0]        cell_index;
        logic signed [15:0] ground_height;
        logic signed [15:0] stream_level;
        logic               stream_connected;
        logic               lake_present;
        logic signed [15:0] lake_level;
    } req_item_t;

    typedef struct packed {
        logic              result_kind;
        logic [DIST_W-1:0] distance;
    } rsp_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_RD_A,
        S_RD_B,
        S_SUM,
        S_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic start_fwd;
        logic start_bwd;
        logic bwd;
        logic load;
        logic rd_item;
        logic rd_cell;
        logic rd_diag;
        logic sum;
        logic wr;
        logic out_read;
        logic out_done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_cell;
        logic out_free;
    } ctrl_sts_t;

endpackage

FILE: design/cdt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chamfer distance transform controller
// Sequences load, read and run items and steps each cell of both passes
// through read, sum and write phases.
// ----------------------------------------------------------------------------
module cdt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [1:0]          req_mode,
    output logic                req_ready,
    input  cdt_pkg::ctrl_sts_t  sts,
    output cdt_pkg::ctrl_cmd_t  cmd
);
    import cdt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   bwd_reg;
    logic   bwd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bwd_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bwd_reg   <= bwd_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        bwd_next   = bwd_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        cmd.bwd    = bwd_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    unique case (req_mode)
                        MODE_LOAD:
                        begin
                            cmd.load = 1'b1;
                        end
                        MODE_RUN:
                        begin
                            cmd.start_fwd = 1'b1;
                            bwd_next      = 1'b0;
                            state_next    = S_RD_A;
                        end
                        MODE_READ:
                        begin
                            cmd.rd_item = 1'b1;
                            state_next  = S_READ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (sts.out_free)
                begin
                    cmd.out_read = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_RD_A:
            begin
                cmd.rd_cell = 1'b1;
                state_next  = S_RD_B;
            end
            S_RD_B:
            begin
                cmd.rd_diag = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.wr = 1'b1;
                if (sts.last_cell)
                begin
                    if (!bwd_reg)
                    begin
                        // The forward pass is over; the backward pass starts at the last cell.
                        cmd.start_bwd = 1'b1;
                        bwd_next      = 1'b1;
                        state_next    = S_RD_A;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_RD_A;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_done = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_mode == MODE_RUN |=> state_reg == S_RD_A)
        else $error("run transfer did not start the forward pass");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_read || cmd.out_done |-> sts.out_free)
        else $error("result loaded while the output register was occupied");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WR && bwd_reg && sts.last_cell |=> state_reg == S_DONE)
        else $error("last backward cell did not finish the run");

endmodule

FILE: design/cdt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chamfer distance transform datapath
// Configuration registers, raster counters, the distance memory with two
// read ports, the saturating relaxation arithmetic and the output register.
// ----------------------------------------------------------------------------
module cdt_datapath #(
    parameter int MAX_SIDE = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cdt_pkg::req_item_t                req_item,
    input  cdt_pkg::ctrl_cmd_t                cmd,
    output cdt_pkg::ctrl_sts_t                sts,
    input  logic                              cfg_we,
    input  logic [cdt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cdt_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output cdt_pkg::rsp_item_t                rsp_item
);
    import cdt_pkg::*;

    localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
    localparam int AW         = $clog2(DEPTH);
    localparam int XW         = $clog2(MAX_SIDE);
    localparam int SW         = $clog2(MAX_SIDE + 1);
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int RESET_SIDE = (MAX_SIDE < RESET_GRID_SIDE) ? MAX_SIDE : RESET_GRID_SIDE;

    function automatic logic [SW-1:0] clamp_side(input logic [GRID_W-1:0] g);
        logic [SW-1:0] r;
        if (32'(g) < 2)
            r = SW'(2);
        else if (32'(g) > MAX_SIDE)
            r = SW'(MAX_SIDE);
        else
            r = SW'(g);
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] d,
                                                  input logic [COST_W-1:0] c);
        logic [DIST_W:0] s;
        s = {1'b0, d} + (DIST_W + 1)'(c);
        return s[DIST_W] ? DIST_INF : s[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] min2(input logic [DIST_W-1:0] a,
                                               input logic [DIST_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // Configuration.
    logic [SW-1:0]     side_reg;
    logic [CW-1:0]     count_reg;
    logic [COST_W-1:0] straight_reg;
    logic [COST_W-1:0] diagonal_reg;
    logic [SW-1:0]     side_wr;
    logic [2*SW-1:0]   square_wr;

    assign side_wr   = clamp_side(cfg_data[GRID_W-1:0]);
    assign square_wr = side_wr * side_wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg     <= SW'(RESET_SIDE);
            count_reg    <= CW'(RESET_SIDE * RESET_SIDE);
            straight_reg <= RESET_STRAIGHT_COST;
            diagonal_reg <= RESET_DIAGONAL_COST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_SIDE:
                begin
                    side_reg  <= side_wr;
                    count_reg <= CW'(square_wr);
                end
                REG_STRAIGHT_COST:
                begin
                    straight_reg <= cfg_data[COST_W-1:0];
                end
                REG_DIAGONAL_COST:
                begin
                    diagonal_reg <= cfg_data[COST_W-1:0];
                end
                default:
                begin
                    side_reg <= side_reg;
                end
            endcase
        end
    end

    // Raster position of the cell being relaxed.
    logic [XW-1:0] col_reg;
    logic [XW-1:0] row_reg;
    logic [AW-1:0] addr_reg;
    logic [SW-1:0] side_m1;
    logic          col_first;
    logic          col_last;
    logic          row_first;
    logic          row_last;
    logic          h_ok;
    logic          v_ok;
    logic          da_ok;
    logic          db_ok;
    logic [AW-1:0] side_a;
    logic [AW-1:0] vert_addr;
    logic [AW-1:0] diag_a_addr;
    logic [AW-1:0] diag_b_addr;

    assign side_m1   = side_reg - SW'(1);
    assign col_first = (col_reg == '0);
    assign row_first = (row_reg == '0);
    assign col_last  = (SW'(col_reg) == side_m1);
    assign row_last  = (SW'(row_reg) == side_m1);
    assign side_a    = AW'(side_reg);

    // The forward pass looks at W, N, NW and NE; the backward pass mirrors to E, S, SE, SW.
    assign h_ok        = cmd.bwd ? !col_last  : !col_first;
    assign v_ok        = cmd.bwd ? !row_last  : !row_first;
    assign da_ok       = v_ok && h_ok;
    assign db_ok       = v_ok && (cmd.bwd ? !col_first : !col_last);
    assign vert_addr   = cmd.bwd ? addr_reg + side_a : addr_reg - side_a;
    assign diag_a_addr = cmd.bwd ? vert_addr + AW'(1) : vert_addr - AW'(1);
    assign diag_b_addr = cmd.bwd ? vert_addr - AW'(1) : vert_addr + AW'(1);

    assign sts.last_cell = cmd.bwd ? (row_first && col_first) : (row_last && col_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            addr_reg <= '0;
        end
        else if (cmd.start_fwd)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            addr_reg <= '0;
        end
        else if (cmd.start_bwd)
        begin
            col_reg  <= XW'(side_m1);
            row_reg  <= XW'(side_m1);
            addr_reg <= AW'(count_reg - CW'(1));
        end
        else if (cmd.wr)
        begin
            if (!cmd.bwd)
            begin
                if (col_last)
                begin
                    col_reg <= '0;
                    row_reg <= XW'(row_reg + XW'(1));
                end
                else
                begin
                    col_reg <= XW'(col_reg + XW'(1));
                end
                addr_reg <= addr_reg + AW'(1);
            end
            else
            begin
                if (col_first)
                begin
                    col_reg <= XW'(side_m1);
                    row_reg <= XW'(row_reg - XW'(1));
                end
                else
                begin
                    col_reg <= XW'(col_reg - XW'(1));
                end
                addr_reg <= addr_reg - AW'(1);
            end
        end
    end

    // Load classification.
    logic              wet;
    logic              in_range;
    logic [AW-1:0]     item_addr;

    assign wet = (req_item.stream_level > req_item.ground_height)
              && (req_item.stream_connected
                  || (req_item.lake_present
                      && (req_item.lake_level > req_item.ground_height)));
    assign in_range  = 32'(req_item.cell_index) < 32'(count_reg);
    assign item_addr = AW'(req_item.cell_index);

    // Distance memory: one write port, two registered read ports.
    logic [DIST_W-1:0] mem [DEPTH];
    logic [DIST_W-1:0] rd0_reg;
    logic [DIST_W-1:0] rd1_reg;
    logic              rd_en;
    logic [AW-1:0]     rd0_addr;
    logic [AW-1:0]     rd1_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DIST_W-1:0] wr_data;
    logic [DIST_W-1:0] best;

    assign rd_en    = cmd.rd_item || cmd.rd_cell || cmd.rd_diag;
    assign rd0_addr = cmd.rd_item ? item_addr : (cmd.rd_cell ? addr_reg : diag_a_addr);
    assign rd1_addr = cmd.rd_cell ? vert_addr : diag_b_addr;
    assign wr_en    = (cmd.load && in_range) || cmd.wr;
    assign wr_addr  = cmd.wr ? addr_reg : item_addr;
    assign wr_data  = cmd.wr ? best : (wet ? '0 : DIST_INF);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd0_reg <= mem[rd0_addr];
            rd1_reg <= mem[rd1_addr];
        end
    end

    // Relaxation: candidates are registered, then the minimum is written back.
    logic [DIST_W-1:0] cur_reg;
    logic [DIST_W-1:0] vert_reg;
    logic [DIST_W-1:0] held_reg;
    logic [DIST_W-1:0] cand_h_reg;
    logic [DIST_W-1:0] cand_v_reg;
    logic [DIST_W-1:0] cand_a_reg;
    logic [DIST_W-1:0] cand_b_reg;
    logic              rd_ok_reg;

    assign best = min2(min2(min2(cur_reg, cand_a_reg), min2(cand_v_reg, cand_h_reg)),
                       cand_b_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.rd_item)
            rd_ok_reg <= in_range;
        if (cmd.rd_diag)
        begin
            cur_reg  <= rd0_reg;
            vert_reg <= rd1_reg;
        end
        if (cmd.sum)
        begin
            // The horizontal neighbor is the value written one cell earlier.
            cand_h_reg <= h_ok  ? sat_add(held_reg, straight_reg) : DIST_INF;
            cand_v_reg <= v_ok  ? sat_add(vert_reg, straight_reg) : DIST_INF;
            cand_a_reg <= da_ok ? sat_add(rd0_reg, diagonal_reg)  : DIST_INF;
            cand_b_reg <= db_ok ? sat_add(rd1_reg, diagonal_reg)  : DIST_INF;
        end
        if (cmd.wr)
            held_reg <= best;
    end

    // Output register.
    logic      rsp_valid_reg;
    rsp_item_t rsp_item_reg;

    assign sts.out_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp_item     = rsp_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.out_read || cmd.out_done)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_read)
        begin
            rsp_item_reg.result_kind <= KIND_READ;
            rsp_item_reg.distance    <= rd_ok_reg ? rd0_reg : DIST_INF;
        end
        else if (cmd.out_done)
        begin
            rsp_item_reg.result_kind <= KIND_DONE;
            rsp_item_reg.distance    <= '0;
        end
    end

    a_one_read: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.rd_item, cmd.rd_cell, cmd.rd_diag}))
        else $error("more than one read source selected");

    a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> (SW'(col_reg) <= side_m1) && (SW'(row_reg) <= side_m1))
        else $error("relaxed cell lies outside the active grid");

    a_fwd_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr && !cmd.bwd && !sts.last_cell && !cmd.start_fwd
        |=> addr_reg == AW'($past(addr_reg) + AW'(1)))
        else $error("forward pass address did not advance by one");

endmodule

FILE: design/chamfer_distance_transform_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chamfer distance transform top level
// Two-pass 8-neighbor chamfer distance engine over a square grid held in
// an on-chip distance memory.
// ----------------------------------------------------------------------------
// Load: written at the transfer edge; a load is taken every cycle while idle.
// Read: the word is registered, then loaded into the output register once it is free.
// Run: each cell of each pass goes through the read, read, sum, write sequence over
//      the memory ports; the finished marker waits for a free output register.
// Reset clears control and the output valid and restores the configuration registers;
// the distance memory is not cleared and holds garbage until cells are loaded.
module chamfer_distance_transform_top #(
    parameter int MAX_SIDE = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  cdt_pkg::req_item_t                req_item,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output cdt_pkg::rsp_item_t                rsp_item,
    input  logic                              cfg_we,
    input  logic [cdt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cdt_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cdt_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    cdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_mode  (req_item.mode),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cdt_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

endmodule

FILE: verif/chamfer_distance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chamfer distance transform checker
// Watches the request, response and register ports of the distance engine,
// keeps its own copy of the distance memory and the registers, computes the
// answer of every accepted read and run request and compares each response with it.
// ----------------------------------------------------------------------------
module chamfer_distance_checker #(
    parameter int MAX_SIDE = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    input  logic                              req_ready,
    input  cdt_pkg::req_item_t                req_item,
    input  logic                              rsp_valid,
    input  logic                              rsp_ready,
    input  cdt_pkg::rsp_item_t                rsp_item,
    input  logic                              cfg_we,
    input  logic [cdt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cdt_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                fail_count,
    output int                                pending_results
);
    import cdt_pkg::*;

    logic [DIST_W-1:0] dist_cells [MAX_SIDE*MAX_SIDE];
    logic [GRID_W-1:0] side_q;
    logic [COST_W-1:0] straight_q;
    logic [COST_W-1:0] diagonal_q;
    rsp_item_t         answers_due [$];

    task automatic report(input string what, input logic [31:0] want,
                          input logic [31:0] got);
        fail_count++;
        $display("[%0t] mismatch: %s, expected %0h, got %0h", $time, what, want, got);
    endtask

    function automatic int grid_side_now();
        int s;
        s = int'(side_q);
        if (s < 2) s = 2;
        if (s > MAX_SIDE) s = MAX_SIDE;
        return s;
    endfunction

    function automatic logic is_wet(input req_item_t it);
        logic above_stream;
        logic above_lake;
        above_stream = $signed(it.stream_level) > $signed(it.ground_height);
        above_lake   = $signed(it.lake_level) > $signed(it.ground_height);
        return above_stream && (it.stream_connected || (it.lake_present && above_lake));
    endfunction

    // Pull a cell down to its neighbor's distance plus the step cost, saturating.
    task automatic relax_cell(input int side, input int x, input int y,
                              input int dx, input int dy, input logic [COST_W-1:0] cost);
        int nx;
        int ny;
        logic [DIST_W:0] cand;
        nx = x + dx;
        ny = y + dy;
        if (nx >= 0 && ny >= 0 && nx < side && ny < side) begin
            cand = {1'b0, dist_cells[ny*side + nx]} + (DIST_W + 1)'(cost);
            if (cand > {1'b0, DIST_INF}) cand = {1'b0, DIST_INF};
            if (cand[DIST_W-1:0] < dist_cells[y*side + x])
                dist_cells[y*side + x] = cand[DIST_W-1:0];
        end
    endtask

    task automatic sweep_grid();
        int side;
        int count;
        int x;
        int y;
        int i;
        side  = grid_side_now();
        count = side * side;
        for (y = 0; y < side; y++) begin
            for (x = 0; x < side; x++) begin
                relax_cell(side, x, y, -1,  0, straight_q);
                relax_cell(side, x, y,  0, -1, straight_q);
                relax_cell(side, x, y, -1, -1, diagonal_q);
                relax_cell(side, x, y,  1, -1, diagonal_q);
            end
        end
        for (i = count - 1; i >= 0; i--) begin
            x = i % side;
            y = i / side;
            relax_cell(side, x, y,  1,  0, straight_q);
            relax_cell(side, x, y,  0,  1, straight_q);
            relax_cell(side, x, y,  1,  1, diagonal_q);
            relax_cell(side, x, y, -1,  1, diagonal_q);
        end
    endtask

    task automatic take_request(input req_item_t it);
        int count;
        rsp_item_t want;
        count = grid_side_now() * grid_side_now();
        case (it.mode)
            MODE_LOAD: begin
                if (int'(it.cell_index) < count)
                    dist_cells[it.cell_index] = is_wet(it) ? '0 : DIST_INF;
            end
            MODE_RUN: begin
                sweep_grid();
                want.result_kind = KIND_DONE;
                want.distance    = '0;
                answers_due.push_back(want);
            end
            MODE_READ: begin
                want.result_kind = KIND_READ;
                want.distance    = (int'(it.cell_index) < count) ?
                                   dist_cells[it.cell_index] : DIST_INF;
                answers_due.push_back(want);
            end
            default: ;
        endcase
    endtask

    task automatic check_response(input rsp_item_t got);
        rsp_item_t want;
        if (answers_due.size() == 0) begin
            report("response with nothing outstanding", 32'd0, 32'(got));
        end
        else begin
            want = answers_due.pop_front();
            if (got.result_kind !== want.result_kind)
                report("result_kind", 32'(want.result_kind), 32'(got.result_kind));
            if (got.distance !== want.distance)
                report("distance", 32'(want.distance), 32'(got.distance));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            side_q     = GRID_W'(RESET_GRID_SIDE);
            straight_q = RESET_STRAIGHT_COST;
            diagonal_q = RESET_DIAGONAL_COST;
            foreach (dist_cells[i]) dist_cells[i] = '0;
            answers_due.delete();
            fail_count      = 0;
            pending_results = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_GRID_SIDE:     side_q     = cfg_data[GRID_W-1:0];
                    REG_STRAIGHT_COST: straight_q = cfg_data[COST_W-1:0];
                    REG_DIAGONAL_COST: diagonal_q = cfg_data[COST_W-1:0];
                    default: ;
                endcase
            end
            if (rsp_valid && rsp_ready) check_response(rsp_item);
            if (req_valid && req_ready) take_request(req_item);
            pending_results = answers_due.size();
        end
    end

endmodule

FILE: verif/chamfer_distance_transform_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chamfer distance transform testbench
// Loads grids of wet and dry cells, runs the two-pass transform and reads
// distances back under a range of grid sides and step costs, with random
// gaps on both handshakes. A checker beside the engine judges every answer.
// ----------------------------------------------------------------------------
module chamfer_distance_transform_top_test;
    import cdt_pkg::*;

    localparam int MAX_SIDE = 256;
    localparam logic [1:0]           MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    req_item_t             req_item;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_item_t             rsp_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending_results;

    bit idle_on;
    int grid_cells;
    int stall_left = 0;

    chamfer_distance_transform_top #(
        .MAX_SIDE (MAX_SIDE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    chamfer_distance_checker #(
        .MAX_SIDE (MAX_SIDE)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req_item        (req_item),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .rsp_item        (rsp_item),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // The receiver stalls in bursts while idling is on.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_ready <= 1'b0;
        end
        else begin
            rsp_ready <= 1'b1;
        end
    end

    function automatic req_item_t cell_load(input int idx, input int wet_permille);
        req_item_t it;
        logic [15:0] g;
        g = 16'($urandom);
        it.mode             = MODE_LOAD;
        it.cell_index       = 16'(idx);
        it.ground_height    = g;
        it.stream_connected = 1'($urandom);
        it.lake_present     = 1'($urandom);
        if ($urandom_range(0, 999) < wet_permille) begin
            it.stream_level = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                              g + 16'($urandom_range(0, 4)) - 16'd2;
            it.lake_level   = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                              g + 16'($urandom_range(0, 4)) - 16'd2;
        end
        else begin
            // A stream level equal to the ground keeps the cell dry.
            it.stream_level = g;
            it.lake_level   = 16'($urandom);
        end
        return it;
    endfunction

    function automatic req_item_t seed_item(input int idx, input logic [15:0] ground,
                                            input logic [15:0] stream, input logic conn,
                                            input logic lake, input logic [15:0] lake_lvl);
        req_item_t it;
        it.mode             = MODE_LOAD;
        it.cell_index       = 16'(idx);
        it.ground_height    = ground;
        it.stream_level     = stream;
        it.stream_connected = conn;
        it.lake_present     = lake;
        it.lake_level       = lake_lvl;
        return it;
    endfunction

    // Other fields carry random values that the engine must ignore.
    function automatic req_item_t query_item(input logic [1:0] mode, input int idx);
        req_item_t it;
        it      = cell_load(idx, 1000);
        it.mode = mode;
        return it;
    endfunction

    task automatic send_req(input req_item_t it);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        @(negedge clk);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] side_data, input logic [15:0] straight,
                             input logic [15:0] diagonal);
        int s;
        wait_idle();
        cfg_write(REG_GRID_SIDE, side_data);
        cfg_write(REG_STRAIGHT_COST, straight);
        cfg_write(REG_DIAGONAL_COST, diagonal);
        s = int'(side_data[GRID_W-1:0]);
        if (s < 2) s = 2;
        if (s > MAX_SIDE) s = MAX_SIDE;
        grid_cells = s * s;
    endtask

    task automatic fill_grid(input int wet_permille);
        for (int i = 0; i < grid_cells; i++) send_req(cell_load(i, wet_permille));
    endtask

    function automatic int pick_index(input int in_range_pct);
        if ($urandom_range(0, 99) < in_range_pct) return $urandom_range(0, grid_cells - 1);
        return $urandom_range(0, 65535);
    endfunction

    task automatic random_traffic(input int n_items, input int wet_permille);
        int sent;
        int r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_req(cell_load(pick_index(90), wet_permille));
                sent++;
            end
            else if (r < 88) begin
                send_req(query_item(MODE_READ, pick_index(80)));
                sent++;
            end
            else if (r < 96) begin
                send_req(query_item(MODE_RUN, $urandom_range(0, 65535)));
                sent++;
            end
            else begin
                send_req(query_item(MODE_UNUSED, $urandom_range(0, 65535)));
            end
        end
    endtask

    function automatic logic [15:0] random_cost();
        case ($urandom_range(0, 5))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 16));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    initial begin
        logic [15:0] side_data;
        logic [15:0] straight;
        logic [15:0] diagonal;

        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_item   = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        idle_on    = 1'b1;
        grid_cells = RESET_GRID_SIDE * RESET_GRID_SIDE;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset registers, then an oversized side that saturates to the maximum.
        send_req(seed_item(0, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 16'h0000));
        send_req(query_item(MODE_READ, 0));
        send_req(seed_item(65535, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'h7FFF));
        send_req(query_item(MODE_READ, 65535));
        configure(16'd511, RESET_STRAIGHT_COST, RESET_DIAGONAL_COST);
        send_req(seed_item(1, 16'h0100, 16'h0101, 1'b0, 1'b1, 16'h0101));
        send_req(seed_item(2, 16'h0100, 16'h0101, 1'b0, 1'b1, 16'h0100));
        send_req(seed_item(3, 16'h0100, 16'h0101, 1'b0, 1'b0, 16'h7FFF));
        send_req(seed_item(4, 16'hFF00, 16'hFF00, 1'b1, 1'b1, 16'h7FFF));
        for (int i = 1; i <= 4; i++) send_req(query_item(MODE_READ, i));
        send_req(query_item(MODE_UNUSED, 0));

        // Smallest grid: ignored load and read beyond the grid, an all-dry run, then one wet cell.
        configure(16'd2, 16'd1, 16'hFFFF);
        for (int i = 0; i < 4; i++)
            send_req(seed_item(i, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0001));
        send_req(seed_item(4, 16'h0000, 16'h0001, 1'b1, 1'b0, 16'h0000));
        send_req(query_item(MODE_READ, 4));
        send_req(query_item(MODE_READ, 65535));
        send_req(query_item(MODE_RUN, 0));
        send_req(query_item(MODE_READ, 0));
        send_req(seed_item(3, 16'h0000, 16'h0001, 1'b1, 1'b0, 16'h0000));
        send_req(query_item(MODE_RUN, 0));
        for (int i = 0; i < 3; i++) send_req(query_item(MODE_READ, i));

        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       side_data = 16'd0;
                1:       side_data = 16'hFE07;
                2:       side_data = 16'd16;
                default: side_data = 16'($urandom_range(3, 12));
            endcase
            case (p)
                0: begin straight = 16'hFFFF; diagonal = 16'hFFFF; end
                1: begin straight = 16'd1;    diagonal = 16'hFFFF; end
                2: begin straight = RESET_STRAIGHT_COST; diagonal = RESET_DIAGONAL_COST; end
                default: begin straight = random_cost(); diagonal = random_cost(); end
            endcase
            idle_on = (p != 5);
            configure(side_data, straight, diagonal);
            if (p == 1) cfg_write(REG_UNUSED, 16'($urandom));
            fill_grid((p == 3) ? 5 : 1000);
            random_traffic(90, (p == 3) ? 5 : 1000);
        end

        // A last grid with sparse seeds, with no idling on either side.
        idle_on = 1'b0;
        configure(16'd10, RESET_STRAIGHT_COST, RESET_DIAGONAL_COST);
        fill_grid(20);
        send_req(query_item(MODE_RUN, 0));
        for (int i = 0; i < 40; i++) send_req(query_item(MODE_READ, $urandom_range(0, 65535)));
        wait_idle();
        repeat (20) @(negedge clk);

        if (fail_count == 0 && pending_results == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: chamfer_distance_transform_top.f
design/cdt_pkg.sv
design/cdt_ctrl.sv
design/cdt_datapath.sv
design/chamfer_distance_transform_top.sv
verif/chamfer_distance_checker.sv
verif/chamfer_distance_transform_top_test.sv
